@@ rtl/tlad_pkg.sv @@
// Shared types and constants for the two-link arm dynamics pipeline.
// Used by two_link_arm_dynamics and tlad_div; depends on nothing.
package tlad_pkg;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_TRIG_STEPS = 16;

    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    localparam int ANG_FRAC = 30;
    localparam int CW       = 34;

    localparam logic [35:0] PI_Q30      = 36'd3373259426;
    localparam logic [35:0] HALF_PI_Q30 = 36'd1686629713;
    localparam logic [35:0] TWO_PI_Q30  = 36'd6746518852;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASS_FIRST   = 3'd0,
        CFG_MASS_SECOND  = 3'd1,
        CFG_COUPLING     = 3'd2,
        CFG_GRAV_FIRST   = 3'd3,
        CFG_GRAV_SECOND  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic               action;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic signed [31:0] m12;
        logic signed [31:0] cor1;
        logic signed [31:0] cor2;
        logic signed [31:0] gr1;
        logic signed [31:0] gr2;
    } side_t;

    function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
        case (i)
            0:       return 34'sd843314857;
            1:       return 34'sd497837830;
            2:       return 34'sd263043837;
            3:       return 34'sd133525159;
            4:       return 34'sd67021687;
            5:       return 34'sd33543516;
            6:       return 34'sd16775851;
            7:       return 34'sd8388437;
            8:       return 34'sd4194283;
            9:       return 34'sd2097149;
            10:      return 34'sd1048576;
            11:      return 34'sd524288;
            12:      return 34'sd262144;
            13:      return 34'sd131072;
            14:      return 34'sd65536;
            15:      return 34'sd32768;
            16:      return 34'sd16384;
            17:      return 34'sd8192;
            18:      return 34'sd4096;
            19:      return 34'sd2048;
            20:      return 34'sd1024;
            21:      return 34'sd512;
            22:      return 34'sd256;
            23:      return 34'sd128;
            default: return '0;
        endcase
    endfunction

endpackage

@@ rtl/tlad_div.sv @@
// Pipelined restoring divider for the acceleration solve, one quotient bit per stage.
// Depends on tlad_pkg; instantiated by two_link_arm_dynamics.
module tlad_div #(
    parameter int FRAC_BITS = tlad_pkg::DEF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [64:0]   num_first,
    input  logic signed [64:0]   num_second,
    input  logic signed [63:0]   den,
    input  tlad_pkg::side_t      side_in,
    output logic                 out_valid,
    output logic signed [31:0]   quo_first,
    output logic signed [31:0]   quo_second,
    output logic                 sing,
    output tlad_pkg::side_t      side_out
);
    import tlad_pkg::*;

    localparam int DVW = (FRAC_BITS + 65 > 97) ? FRAC_BITS + 65 : 97;
    localparam int QW  = 32;
    localparam int NS  = QW + 3;

    typedef struct packed {
        logic [DVW-1:0] rem;
        logic [QW-1:0]  quo;
        logic           ovf;
        logic           neg;
    } lane_t;

    lane_t              lane_reg [QW+2][2];
    logic [63:0]        ud_reg   [QW+2];
    logic               sing_reg [QW+2];
    side_t              side_reg [QW+2];
    logic [NS-1:0]      vld_reg;
    logic signed [64:0] num [2];

    logic signed [31:0] quo_first_reg;
    logic signed [31:0] quo_second_reg;
    logic               sing_o_reg;
    side_t              side_o_reg;

    assign num[0] = num_first;
    assign num[1] = num_second;

    function automatic logic signed [31:0] sat_quo(input lane_t v);
        logic [QW:0] mag;
        mag = v.ovf ? {1'b1, {QW{1'b0}}} : {1'b0, v.quo};
        if (v.neg) begin
            if (mag[QW:QW-1] != 2'b00) begin
                return 32'sh8000_0000;
            end
            return -$signed(mag[31:0]);
        end
        if (mag[QW:QW-1] != 2'b00) begin
            return 32'sh7FFF_FFFF;
        end
        return $signed(mag[31:0]);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
            begin
                lane_reg[0][l].rem <= DVW'(num[l][64] ? $unsigned(-num[l])
                                                      : $unsigned(num[l])) << FRAC_BITS;
                lane_reg[0][l].quo <= '0;
                lane_reg[0][l].ovf <= 1'b0;
                lane_reg[0][l].neg <= num[l][64] ^ den[63];
            end
            ud_reg[0]   <= den[63] ? $unsigned(-den) : $unsigned(den);
            sing_reg[0] <= (den == '0);
            side_reg[0] <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_t nx;
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
            begin
                nx     = lane_reg[0][l];
                nx.ovf = lane_reg[0][l].rem >= (DVW'(ud_reg[0]) << QW);
                lane_reg[1][l] <= nx;
            end
            ud_reg[1]   <= ud_reg[0];
            sing_reg[1] <= sing_reg[0];
            side_reg[1] <= side_reg[0];
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        localparam int J = QW - 1 - k;
        always_ff @(posedge clk)
        begin
            lane_t nx;
            if (adv)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    nx = lane_reg[k+1][l];
                    if (nx.rem >= (DVW'(ud_reg[k+1]) << J))
                    begin
                        nx.rem    = nx.rem - (DVW'(ud_reg[k+1]) << J);
                        nx.quo[J] = 1'b1;
                    end
                    lane_reg[k+2][l] <= nx;
                end
                ud_reg[k+2]   <= ud_reg[k+1];
                sing_reg[k+2] <= sing_reg[k+1];
                side_reg[k+2] <= side_reg[k+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quo_first_reg  <= sing_reg[QW+1] ? '0 : sat_quo(lane_reg[QW+1][0]);
            quo_second_reg <= sing_reg[QW+1] ? '0 : sat_quo(lane_reg[QW+1][1]);
            sing_o_reg     <= sing_reg[QW+1];
            side_o_reg     <= side_reg[QW+1];
        end
    end

    assign out_valid  = vld_reg[NS-1];
    assign quo_first  = quo_first_reg;
    assign quo_second = quo_second_reg;
    assign sing       = sing_o_reg;
    assign side_out   = side_o_reg;

endmodule

@@ rtl/two_link_arm_dynamics.sv @@
// Two-link arm inverse and forward dynamics, fully pipelined datapath.
// Depends on tlad_pkg and tlad_div.
//
//  channel   direction  handshake              payload
//  request   in         req_valid / req_stall  action, angles, rates, vec_in pair
//  response  out        rsp_valid / rsp_stall  vec_out pair, mass, Coriolis, gravity, singular
//  config    in         cfg_we                 cfg_index, cfg_data
//
// One transaction per cycle unless rsp_stall holds it; the pipe has the CORDIC stages plus
// the 32-stage quotient pipe of the acceleration solve, among other stages.
// Reset loads the default registers and empties the pipe; no clearing pass.
// rsp_stall on a valid response freezes every stage and raises req_stall.
module two_link_arm_dynamics #(
    parameter int FRAC_BITS  = tlad_pkg::DEF_FRAC_BITS,
    parameter int TRIG_STEPS = tlad_pkg::DEF_TRIG_STEPS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              action,
    input  logic signed [18:0]                angle_first,
    input  logic signed [18:0]                angle_second,
    input  logic signed [31:0]                rate_first,
    input  logic signed [31:0]                rate_second,
    input  logic signed [31:0]                vec_in_first,
    input  logic signed [31:0]                vec_in_second,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic signed [31:0]                vec_out_first,
    output logic signed [31:0]                vec_out_second,
    output logic signed [31:0]                mass_off_diag,
    output logic signed [31:0]                coriolis_first,
    output logic signed [31:0]                coriolis_second,
    output logic signed [31:0]                gravity_first,
    output logic signed [31:0]                gravity_second,
    output logic                              singular,
    input  logic                              cfg_we,
    input  logic [tlad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlad_pkg::CFG_W-1:0]        cfg_data
);
    import tlad_pkg::*;

    localparam int SH        = ANG_FRAC - FRAC_BITS;
    localparam int ZW        = (52 - FRAC_BITS > 36) ? 52 - FRAC_BITS : 36;
    localparam int RED_STEPS = (FRAC_BITS < 17) ? 18 - FRAC_BITS : 1;
    localparam int NV        = TRIG_STEPS + 11;

    localparam logic [ZW-1:0]        TWO_PI_Z = ZW'(TWO_PI_Q30);
    localparam logic signed [ZW-1:0] TWO_PI_S = $signed(ZW'(TWO_PI_Q30));
    localparam logic signed [ZW-1:0] PI_S     = $signed(ZW'(PI_Q30));
    localparam logic signed [ZW-1:0] HALF_S   = $signed(ZW'(HALF_PI_Q30));

    typedef struct packed {
        logic               action;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic signed [31:0] e1;
        logic signed [31:0] e2;
    } carry_t;

    logic [CFG_W-1:0] mass1_reg, mass2_reg, coup_reg, grav1_reg, grav2_reg;
    logic signed [31:0] m11_s, m22_s, k_s, g1_s, g2_s;

    logic          adv;
    logic [NV-1:0] vld_reg;

    logic signed [19:0] ang_a_reg [3];
    carry_t             carry_a_reg;

    logic [ZW-1:0] mag_b_next [3];
    logic          neg_b_next [3];
    logic [ZW-1:0] mag_b_reg  [3];
    logic          neg_b_reg  [3];
    carry_t        carry_b_reg;

    logic signed [CW-1:0] z0_next   [3];
    logic                 flip_next [3];

    logic signed [CW-1:0] cx_reg   [TRIG_STEPS+1][3];
    logic signed [CW-1:0] cy_reg   [TRIG_STEPS+1][3];
    logic signed [CW-1:0] cz_reg   [TRIG_STEPS+1][3];
    logic                 flip_reg [TRIG_STEPS+1][3];
    carry_t               carry_c_reg [TRIG_STEPS+1];

    logic signed [31:0] sd_reg, cd_reg, c1_reg, c2_reg;
    carry_t             carry_t_reg;

    logic signed [63:0] p_mc_reg, p_ms_reg, p_v1_reg, p_v2_reg, p_g1_reg, p_g2_reg;
    carry_t             carry_1_reg;

    logic signed [31:0] m12_2_reg, com_2_reg, vv1_2_reg, vv2_2_reg, gr1_2_reg, gr2_2_reg;
    carry_t             carry_2_reg;

    logic signed [63:0] p_c1_reg, p_c2_reg, p_a1_reg, p_a2_reg, p_b1_reg, p_b2_reg;
    logic signed [63:0] p_d0_reg, p_d1_reg;
    logic signed [31:0] m12_3_reg, gr1_3_reg, gr2_3_reg;
    carry_t             carry_3_reg;

    logic signed [31:0] cor1_4_reg, cor2_4_reg, a1_4_reg, a2_4_reg, b1_4_reg, b2_4_reg;
    logic signed [31:0] m12_4_reg, gr1_4_reg, gr2_4_reg;
    logic signed [63:0] det_4_reg;
    carry_t             carry_4_reg;

    side_t              side_5_reg;
    logic signed [31:0] t1_5_reg, t2_5_reg;
    logic signed [63:0] det_5_reg;

    logic signed [63:0] p_n11_reg, p_n12_reg, p_n21_reg, p_n22_reg;
    logic signed [63:0] det_6_reg;
    side_t              side_6_reg;

    logic signed [64:0] num1_7_reg, num2_7_reg;
    logic signed [63:0] det_7_reg;
    side_t              side_7_reg;

    logic               div_valid;
    logic signed [31:0] quo1, quo2;
    logic               sing_o;
    side_t              side_o;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qsh(input logic signed [63:0] p);
        return sat64(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] trig_out(input logic signed [CW-1:0] v,
                                                    input logic f);
        logic signed [CW-1:0] t;
        t = f ? -v : v;
        return 32'(t >>> SH);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass1_reg <= CFG_W'(65536);
            mass2_reg <= CFG_W'(65536);
            coup_reg  <= '0;
            grav1_reg <= '0;
            grav2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MASS_FIRST:  mass1_reg <= cfg_data;
                CFG_MASS_SECOND: mass2_reg <= cfg_data;
                CFG_COUPLING:    coup_reg  <= cfg_data;
                CFG_GRAV_FIRST:  grav1_reg <= cfg_data;
                CFG_GRAV_SECOND: grav2_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign m11_s = $signed({1'b0, mass1_reg});
    assign m22_s = $signed({1'b0, mass2_reg});
    assign k_s   = $signed({1'b0, coup_reg});
    assign g1_s  = $signed({1'b0, grav1_reg});
    assign g2_s  = $signed({1'b0, grav2_reg});

    assign adv       = !rsp_valid || !rsp_stall;
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NV-2:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_a_reg[0] <= 20'(angle_second) - 20'(angle_first);
            ang_a_reg[1] <= 20'(angle_first);
            ang_a_reg[2] <= 20'(angle_second);
            carry_a_reg  <= '{action: action, v1: rate_first, v2: rate_second,
                              e1: vec_in_first, e2: vec_in_second};
        end
    end

    always_comb
    begin
        logic signed [ZW-1:0] zs;
        logic [ZW-1:0]        m;
        for (int l = 0; l < 3; l++)
        begin
            zs = ZW'(ang_a_reg[l]) <<< SH;
            m  = zs[ZW-1] ? $unsigned(-zs) : $unsigned(zs);
            for (int j = RED_STEPS - 1; j >= 0; j--)
            begin
                if (m >= (TWO_PI_Z << j))
                begin
                    m = m - (TWO_PI_Z << j);
                end
            end
            mag_b_next[l] = m;
            neg_b_next[l] = ang_a_reg[l][19];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_b_reg   <= mag_b_next;
            neg_b_reg   <= neg_b_next;
            carry_b_reg <= carry_a_reg;
        end
    end

    always_comb
    begin
        logic signed [ZW-1:0] r;
        logic                 f;
        for (int l = 0; l < 3; l++)
        begin
            r = neg_b_reg[l] ? -$signed(mag_b_reg[l]) : $signed(mag_b_reg[l]);
            if (r > PI_S)
            begin
                r = r - TWO_PI_S;
            end
            else if (r <= -PI_S)
            begin
                r = r + TWO_PI_S;
            end
            f = 1'b0;
            if (r > HALF_S)
            begin
                r = r - PI_S;
                f = 1'b1;
            end
            else if (r < -HALF_S)
            begin
                r = r + PI_S;
                f = 1'b1;
            end
            z0_next[l]   = CW'(r);
            flip_next[l] = f;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                cx_reg[0][l]   <= CORDIC_GAIN_Q30;
                cy_reg[0][l]   <= '0;
                cz_reg[0][l]   <= z0_next[l];
                flip_reg[0][l] <= flip_next[l];
            end
            carry_c_reg[0] <= carry_b_reg;
        end
    end

    for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (!cz_reg[i][l][CW-1])
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] - (cy_reg[i][l] >>> i);
                        cy_reg[i+1][l] <= cy_reg[i][l] + (cx_reg[i][l] >>> i);
                        cz_reg[i+1][l] <= cz_reg[i][l] - atan_q30(i);
                    end
                    else
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] + (cy_reg[i][l] >>> i);
                        cy_reg[i+1][l] <= cy_reg[i][l] - (cx_reg[i][l] >>> i);
                        cz_reg[i+1][l] <= cz_reg[i][l] + atan_q30(i);
                    end
                    flip_reg[i+1][l] <= flip_reg[i][l];
                end
                carry_c_reg[i+1] <= carry_c_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg      <= trig_out(cy_reg[TRIG_STEPS][0], flip_reg[TRIG_STEPS][0]);
            cd_reg      <= trig_out(cx_reg[TRIG_STEPS][0], flip_reg[TRIG_STEPS][0]);
            c1_reg      <= trig_out(cx_reg[TRIG_STEPS][1], flip_reg[TRIG_STEPS][1]);
            c2_reg      <= trig_out(cx_reg[TRIG_STEPS][2], flip_reg[TRIG_STEPS][2]);
            carry_t_reg <= carry_c_reg[TRIG_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_mc_reg    <= k_s * cd_reg;
            p_ms_reg    <= k_s * sd_reg;
            p_v1_reg    <= carry_t_reg.v1 * carry_t_reg.v1;
            p_v2_reg    <= carry_t_reg.v2 * carry_t_reg.v2;
            p_g1_reg    <= g1_s * c1_reg;
            p_g2_reg    <= g2_s * c2_reg;
            carry_1_reg <= carry_t_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m12_2_reg   <= qsh(p_mc_reg);
            com_2_reg   <= qsh(p_ms_reg);
            vv1_2_reg   <= qsh(p_v1_reg);
            vv2_2_reg   <= qsh(p_v2_reg);
            gr1_2_reg   <= qsh(p_g1_reg);
            gr2_2_reg   <= qsh(p_g2_reg);
            carry_2_reg <= carry_1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_c1_reg    <= com_2_reg * vv2_2_reg;
            p_c2_reg    <= com_2_reg * vv1_2_reg;
            p_a1_reg    <= m11_s * carry_2_reg.e1;
            p_a2_reg    <= m12_2_reg * carry_2_reg.e2;
            p_b1_reg    <= m12_2_reg * carry_2_reg.e1;
            p_b2_reg    <= m22_s * carry_2_reg.e2;
            p_d0_reg    <= m11_s * m22_s;
            p_d1_reg    <= m12_2_reg * m12_2_reg;
            m12_3_reg   <= m12_2_reg;
            gr1_3_reg   <= gr1_2_reg;
            gr2_3_reg   <= gr2_2_reg;
            carry_3_reg <= carry_2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cor1_4_reg  <= sat64(-(64'(qsh(p_c1_reg))));
            cor2_4_reg  <= qsh(p_c2_reg);
            a1_4_reg    <= qsh(p_a1_reg);
            a2_4_reg    <= qsh(p_a2_reg);
            b1_4_reg    <= qsh(p_b1_reg);
            b2_4_reg    <= qsh(p_b2_reg);
            det_4_reg   <= p_d0_reg - p_d1_reg;
            m12_4_reg   <= m12_3_reg;
            gr1_4_reg   <= gr1_3_reg;
            gr2_4_reg   <= gr2_3_reg;
            carry_4_reg <= carry_3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_5_reg.action <= carry_4_reg.action;
            side_5_reg.r1     <= sat64(64'(a1_4_reg) + 64'(a2_4_reg)
                                       + 64'(cor1_4_reg) + 64'(gr1_4_reg));
            side_5_reg.r2     <= sat64(64'(b1_4_reg) + 64'(b2_4_reg)
                                       + 64'(cor2_4_reg) + 64'(gr2_4_reg));
            side_5_reg.m12    <= m12_4_reg;
            side_5_reg.cor1   <= cor1_4_reg;
            side_5_reg.cor2   <= cor2_4_reg;
            side_5_reg.gr1    <= gr1_4_reg;
            side_5_reg.gr2    <= gr2_4_reg;
            t1_5_reg  <= sat64(64'(carry_4_reg.e1) - 64'(cor1_4_reg) - 64'(gr1_4_reg));
            t2_5_reg  <= sat64(64'(carry_4_reg.e2) - 64'(cor2_4_reg) - 64'(gr2_4_reg));
            det_5_reg <= det_4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_n11_reg  <= m22_s * t1_5_reg;
            p_n12_reg  <= side_5_reg.m12 * t2_5_reg;
            p_n21_reg  <= m11_s * t2_5_reg;
            p_n22_reg  <= side_5_reg.m12 * t1_5_reg;
            det_6_reg  <= det_5_reg;
            side_6_reg <= side_5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num1_7_reg <= 65'(p_n11_reg) - 65'(p_n12_reg);
            num2_7_reg <= 65'(p_n21_reg) - 65'(p_n22_reg);
            det_7_reg  <= det_6_reg;
            side_7_reg <= side_6_reg;
        end
    end

    tlad_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (vld_reg[NV-1]),
        .num_first  (num1_7_reg),
        .num_second (num2_7_reg),
        .den        (det_7_reg),
        .side_in    (side_7_reg),
        .out_valid  (div_valid),
        .quo_first  (quo1),
        .quo_second (quo2),
        .sing       (sing_o),
        .side_out   (side_o)
    );

    assign rsp_valid       = div_valid;
    assign vec_out_first   = side_o.action ? quo1 : side_o.r1;
    assign vec_out_second  = side_o.action ? quo2 : side_o.r2;
    assign mass_off_diag   = side_o.m12;
    assign coriolis_first  = side_o.cor1;
    assign coriolis_second = side_o.cor2;
    assign gravity_first   = side_o.gr1;
    assign gravity_second  = side_o.gr2;
    assign singular        = side_o.action & sing_o;

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && singular |-> vec_out_first == '0 && vec_out_second == '0)
        else $error("singular response carries nonzero acceleration");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while response stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> vld_reg[0])
        else $error("accepted transaction missing from first stage");

endmodule

@@ sim/arm_dyn_checker.sv @@
// Checker for two_link_arm_dynamics: watches the request, response and config
// ports, predicts each response in fixed point and compares field by field.
// Depends on tlad_pkg.
`timescale 1ns / 100ps

module arm_dyn_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  logic                           action,
    input  logic signed [18:0]             angle_first,
    input  logic signed [18:0]             angle_second,
    input  logic signed [31:0]             rate_first,
    input  logic signed [31:0]             rate_second,
    input  logic signed [31:0]             vec_in_first,
    input  logic signed [31:0]             vec_in_second,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic signed [31:0]             vec_out_first,
    input  logic signed [31:0]             vec_out_second,
    input  logic signed [31:0]             mass_off_diag,
    input  logic signed [31:0]             coriolis_first,
    input  logic signed [31:0]             coriolis_second,
    input  logic signed [31:0]             gravity_first,
    input  logic signed [31:0]             gravity_second,
    input  logic                           singular,
    input  logic                           cfg_we,
    input  logic [tlad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlad_pkg::CFG_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending
);
    import tlad_pkg::*;

    localparam int FRAC  = DEF_FRAC_BITS;
    localparam int STEPS = DEF_TRIG_STEPS;

    typedef struct {
        logic signed [31:0] out1;
        logic signed [31:0] out2;
        logic signed [31:0] m12;
        logic signed [31:0] cor1;
        logic signed [31:0] cor2;
        logic signed [31:0] gr1;
        logic signed [31:0] gr2;
        logic               sing;
    } dynamics_t;

    dynamics_t  expected_dynamics[$];
    logic [CFG_W-1:0] inertia1, inertia2, coupling, grav1, grav2;

    assign pending = expected_dynamics.size();

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return clamp32((a * b) >>> FRAC);
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     flip;
        z    = ang * (64'sd1 <<< (ANG_FRAC - FRAC));
        x    = longint'(CORDIC_GAIN_Q30);
        y    = 0;
        flip = 0;
        z    = z % longint'(TWO_PI_Q30);
        if (z > longint'(PI_Q30))
            z -= longint'(TWO_PI_Q30);
        if (z <= -longint'(PI_Q30))
            z += longint'(TWO_PI_Q30);
        if (z > longint'(HALF_PI_Q30))
        begin
            z -= longint'(PI_Q30);
            flip = 1;
        end
        else if (z < -longint'(HALF_PI_Q30))
        begin
            z += longint'(PI_Q30);
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_q30(i));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_q30(i));
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y >>> (ANG_FRAC - FRAC);
        c = x >>> (ANG_FRAC - FRAC);
    endtask

    function automatic longint fx_div(input longint num, input longint den);
        bit                neg;
        longint unsigned   un, ud, q, r;
        longint unsigned   cap;
        neg = (num < 0) != (den < 0);
        un  = num < 0 ? -num : num;
        ud  = den < 0 ? -den : den;
        q   = un / ud;
        r   = un % ud;
        cap = 64'd1 << 32;
        for (int i = 0; i < FRAC; i++)
        begin
            if (q >= cap)
                break;
            q = q << 1;
            r = r << 1;
            if (r >= ud)
            begin
                r -= ud;
                q |= 1;
            end
        end
        if (q > cap)
            q = cap;
        return clamp32(neg ? -longint'(q) : longint'(q));
    endfunction

    task automatic predict_dynamics(output dynamics_t d);
        longint q1, q2, e1, e2, v1, v2, m11, m22, k;
        longint sd, cd, s1, c1, s2, c2, m12, common, t1, t2, det, r1, r2;
        q1  = angle_first;
        q2  = angle_second;
        v1  = rate_first;
        v2  = rate_second;
        e1  = vec_in_first;
        e2  = vec_in_second;
        m11 = inertia1;
        m22 = inertia2;
        k   = coupling;
        sin_cos(q2 - q1, sd, cd);
        sin_cos(q1, s1, c1);
        sin_cos(q2, s2, c2);
        m12    = fx_mul(k, cd);
        common = fx_mul(k, sd);
        d.m12  = m12;
        d.cor1 = clamp32(-fx_mul(common, fx_mul(v2, v2)));
        d.cor2 = fx_mul(common, fx_mul(v1, v1));
        d.gr1  = fx_mul(longint'(grav1), c1);
        d.gr2  = fx_mul(longint'(grav2), c2);
        d.sing = 0;
        if (!action)
        begin
            r1 = clamp32(fx_mul(m11, e1) + fx_mul(m12, e2) + d.cor1 + d.gr1);
            r2 = clamp32(fx_mul(m12, e1) + fx_mul(m22, e2) + d.cor2 + d.gr2);
        end
        else
        begin
            t1  = clamp32(e1 - d.cor1 - d.gr1);
            t2  = clamp32(e2 - d.cor2 - d.gr2);
            det = m11 * m22 - m12 * m12;
            if (det == 0)
            begin
                d.sing = 1;
                r1 = 0;
                r2 = 0;
            end
            else
            begin
                r1 = fx_div(m22 * t1 - m12 * t2, det);
                r2 = fx_div(m11 * t2 - m12 * t1, det);
            end
        end
        d.out1 = r1;
        d.out2 = r2;
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
    end

    always @(posedge clk)
    begin
        dynamics_t d;
        if (!rst_n)
        begin
            inertia1 <= 31'd65536;
            inertia2 <= 31'd65536;
            coupling <= '0;
            grav1    <= '0;
            grav2    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MASS_FIRST:  inertia1 <= cfg_data;
                    CFG_MASS_SECOND: inertia2 <= cfg_data;
                    CFG_COUPLING:    coupling <= cfg_data;
                    CFG_GRAV_FIRST:  grav1    <= cfg_data;
                    CFG_GRAV_SECOND: grav2    <= cfg_data;
                    default:         ;
                endcase
            end
            if (req_valid && !req_stall)
            begin
                predict_dynamics(d);
                expected_dynamics.push_back(d);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_dynamics.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    errors++;
                end
                else
                begin
                    d = expected_dynamics.pop_front();
                    check_field("vec_out_first", d.out1, vec_out_first);
                    check_field("vec_out_second", d.out2, vec_out_second);
                    check_field("mass_off_diag", d.m12, mass_off_diag);
                    check_field("coriolis_first", d.cor1, coriolis_first);
                    check_field("coriolis_second", d.cor2, coriolis_second);
                    check_field("gravity_first", d.gr1, gravity_first);
                    check_field("gravity_second", d.gr2, gravity_second);
                    check_field("singular", d.sing, singular);
                end
            end
        end
    end

endmodule

@@ sim/tb.sv @@
// Top testbench for two_link_arm_dynamics: clock, reset, stimulus phases and verdict.
// Depends on tlad_pkg, two_link_arm_dynamics and arm_dyn_checker.
`timescale 1ns / 100ps

module tb;
    import tlad_pkg::*;

    localparam int LATENCY     = DEF_TRIG_STEPS + 46;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 325;
    localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    logic                 action;
    logic signed [18:0]   angle_first;
    logic signed [18:0]   angle_second;
    logic signed [31:0]   rate_first;
    logic signed [31:0]   rate_second;
    logic signed [31:0]   vec_in_first;
    logic signed [31:0]   vec_in_second;
    logic                 rsp_valid;
    logic                 rsp_stall;
    logic signed [31:0]   vec_out_first;
    logic signed [31:0]   vec_out_second;
    logic signed [31:0]   mass_off_diag;
    logic signed [31:0]   coriolis_first;
    logic signed [31:0]   coriolis_second;
    logic signed [31:0]   gravity_first;
    logic signed [31:0]   gravity_second;
    logic                 singular;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors;
    int                   pending;
    int                   idle_pct;
    int                   stall_pct;
    int                   quiet_cycles;

    two_link_arm_dynamics DUT (.*);
    arm_dyn_checker checker_inst (.*);

    initial
    begin
        clk = 0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        rsp_stall = 0;
        stall_pct = 0;
        forever
        begin
            @(negedge clk);
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3:       return $urandom_range(3);
            default: return $signed($urandom) >>> $urandom_range(31, 6);
        endcase
    endfunction

    function automatic logic [18:0] pick_angle();
        int a;
        if ($urandom_range(7) == 0)
            return 19'($urandom);
        a = int'($urandom_range(411774)) - 205887;
        return a[18:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 0;
    endtask

    task automatic send(input logic act, input logic [18:0] a1, input logic [18:0] a2,
                        input logic [31:0] w1, input logic [31:0] w2,
                        input logic [31:0] x1, input logic [31:0] x2);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 0;
            @(negedge clk);
        end
        req_valid     <= 1;
        action        <= act;
        angle_first   <= a1;
        angle_second  <= a2;
        rate_first    <= w1;
        rate_second   <= w2;
        vec_in_first  <= x1;
        vec_in_second <= x2;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_config(input int phase);
        logic [CFG_W-1:0] v[5];
        case (phase)
            0: v = '{31'd65536, 31'd65536, CFG_MAX, CFG_MAX, CFG_MAX};
            1: v = '{31'd0, 31'd0, 31'd0, 31'd0, 31'd0};
            2: v = '{CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX};
            3: v = '{CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                     CFG_W'($urandom), CFG_W'($urandom)};
            4: v = '{CFG_W'($urandom_range(1 << 20)), CFG_W'($urandom_range(1 << 20)),
                     CFG_W'($urandom_range(1 << 20)), CFG_W'($urandom_range(1 << 20)),
                     CFG_W'($urandom_range(1 << 20))};
            default: v = '{31'd65536, 31'd65536, 31'd65536, CFG_W'($urandom),
                           CFG_W'($urandom)};
        endcase
        write_reg(CFG_MASS_FIRST, v[0]);
        write_reg(CFG_MASS_SECOND, v[1]);
        write_reg(CFG_COUPLING, v[2]);
        write_reg(CFG_GRAV_FIRST, v[3]);
        write_reg(CFG_GRAV_SECOND, v[4]);
        for (int i = 1; i <= 3; i++)
            write_reg(CFG_IDX_W'(CFG_GRAV_SECOND + i), CFG_W'($urandom));
    endtask

    initial
    begin
        rst_n         = 0;
        req_valid     = 0;
        action        = 0;
        angle_first   = '0;
        angle_second  = '0;
        rate_first    = '0;
        rate_second   = '0;
        vec_in_first  = '0;
        vec_in_second = '0;
        cfg_we        = 0;
        cfg_index     = CFG_MASS_FIRST;
        cfg_data      = '0;
        idle_pct      = 0;
        quiet_cycles  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reset values first
        send(0, 19'sd1000, -19'sd3000, 32'sd65536, -32'sd131072, 32'sd65536, 32'sd65536);
        send(1, 19'sd0, 19'sd0, 32'sd0, 32'sd0, -32'sd65536, 32'sd200000);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            load_config(phase);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            if (phase == 0)
            begin
                for (int act = 0; act < 2; act++)
                begin
                    send(act, 19'sd205887, -19'sd205887, 32'h7fff_ffff, 32'h8000_0000,
                         32'h7fff_ffff, 32'h8000_0000);
                    send(act, -19'sd205887, 19'sd205887, 32'h8000_0000, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff);
                    send(act, 19'h3ffff, 19'h40000, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
                    send(act, 19'h40000, 19'h3ffff, 32'sd65536, 32'sd65536, -32'sd1, 32'sd1);
                    // Coriolis term at the negative limit, negated
                    send(act, 19'sd102944, 19'sd0, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'sd0, 32'sd0);
                    send(act, 19'sd0, 19'sd102944, 32'h8000_0000, 32'h8000_0000,
                         32'sd65536, 32'sd0);
                    send(act, 19'sd51472, 19'sd51472, 32'sd1, -32'sd1, 32'h7fff_ffff,
                         32'h7fff_ffff);
                    send(act, 19'sd0, 19'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
                end
            end
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                send($urandom_range(1), pick_angle(), pick_angle(), pick_word(), pick_word(),
                     pick_word(), pick_word());
            end
            drain();
        end

        idle_pct  = 0;
        stall_pct = 0;
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
